// ===== sv/lfu_pkg.sv =====
// ----------------------------------------------------------------------------
// lfu_pkg: shared types and constants of the LFU cache engine
// Request and response words, command codes, cell broadcast opcodes and the
// control FSM states.
// ----------------------------------------------------------------------------
package lfu_pkg;

  localparam int unsigned CAP_W = 5;
  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef logic signed [31:0] word_t;

  localparam word_t READ_MISS = -32'sd1;
  localparam word_t READ_PUT  = 32'sd0;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e  command;
    word_t key;
    word_t value;
  } req_t;

  typedef struct packed {
    logic  found;
    word_t read_value;
  } rsp_t;

  // Operation broadcast to every cell at the end of a sweep
  typedef enum logic [1:0] {
    OP_NONE,
    OP_TOUCH,
    OP_FILL
  } op_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SEED,
    S_SWEEP
  } state_e;

endpackage

// ===== sv/lfu_cell.sv =====
// ----------------------------------------------------------------------------
// lfu_cell: one entry of the LFU cache
// Holds key, value, use count and recency rank of one slot, folds its entry
// into the search token passing by, and applies the broadcast update.
// ----------------------------------------------------------------------------
module lfu_cell #(
  parameter int unsigned IDX        = 0,
  parameter int unsigned IB         = 4,
  parameter int unsigned COUNT_BITS = 16,
  parameter type tok_t   = logic,
  parameter type bcast_t = logic
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lfu_pkg::req_t req_i,
  input  bcast_t        bcast_i,
  input  tok_t          tok_i,
  output tok_t          tok_o,
  output logic          valid_o
);
  import lfu_pkg::*;

  logic                  valid_q;
  word_t                 key_q;
  word_t                 value_q;
  logic [COUNT_BITS-1:0] cnt_q;
  logic [IB-1:0]         rank_q;
  tok_t                  tok_d;
  tok_t                  tok_q;
  logic                  match;
  logic                  target;
  logic                  older;

  assign match  = valid_q && (key_q == req_i.key);
  assign target = (bcast_i.idx == IB'(IDX));
  assign older  = valid_q && (rank_q < bcast_i.rank);

  // Fold this entry into the passing token
  always_comb begin
    tok_d = tok_i;
    if (valid_q) begin
      if (match) begin
        tok_d.hit      = 1'b1;
        tok_d.hit_val  = value_q;
        tok_d.hit_rank = rank_q;
      end
      if (!tok_i.have_vic || (cnt_q < tok_i.vic_cnt) ||
          ((cnt_q == tok_i.vic_cnt) && (rank_q > tok_i.vic_rank))) begin
        tok_d.have_vic = 1'b1;
        tok_d.vic_idx  = IB'(IDX);
        tok_d.vic_cnt  = cnt_q;
        tok_d.vic_rank = rank_q;
      end
    end else if (!tok_i.have_free) begin
      tok_d.have_free = 1'b1;
      tok_d.free_idx  = IB'(IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if ((bcast_i.op == OP_FILL) && target) begin
      valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    case (bcast_i.op)
      OP_TOUCH: begin
        if (match) begin
          rank_q <= '0;
          if (cnt_q != '1) begin
            cnt_q <= cnt_q + COUNT_BITS'(1);
          end
          if (bcast_i.write_val) begin
            value_q <= req_i.value;
          end
        end else if (older) begin
          rank_q <= rank_q + IB'(1);
        end
      end
      OP_FILL: begin
        if (target) begin
          key_q   <= req_i.key;
          value_q <= req_i.value;
          cnt_q   <= COUNT_BITS'(1);
          rank_q  <= '0;
        end else if (valid_q && (bcast_i.bump_all || older)) begin
          rank_q <= rank_q + IB'(1);
        end
      end
      default: begin
      end
    endcase
  end

  assign tok_o   = tok_q;
  assign valid_o = valid_q;

endmodule

// ===== sv/lfu_cache_engine.sv =====
// ----------------------------------------------------------------------------
// lfu_cache_engine: key-value cache with LFU replacement, LRU tie break
// Row of entry cells swept by a search token, plus request control.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: present a word on req_i and raise start; it is taken at
//   a rising edge where busy is low. command GET looks a key up, PUT inserts
//   or updates it while the capacity register is nonzero.
//   Response channel: exactly one response word per request, shown on rsp_o
//   for a single cycle while done_o is high. The receiver cannot stall; it
//   must take the word in that cycle.
//   Configuration: cfg_we_i writes cfg_wdata_i into the capacity register;
//   write it only while the engine is idle.
//   Timing: after acceptance the seed state injects a search token into cell
//   0; the token advances one cell per cycle through the registered cells.
//   The edge that ends the sweep updates all cells at once and registers the
//   response and done_o. busy stays high from acceptance until that edge, so
//   a new request is taken only after the last one is through; the next
//   request can be taken at the end of the cycle in which done_o is high.
//   Reset: clears every entry valid bit, the occupancy count and the FSM,
//   and loads the capacity register with 16.
// ----------------------------------------------------------------------------
module lfu_cache_engine #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned COUNT_BITS  = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  lfu_pkg::req_t              req_i,
  output logic                       done_o,
  output lfu_pkg::rsp_t              rsp_o,
  input  logic                       cfg_we_i,
  input  logic [lfu_pkg::CAP_W-1:0]  cfg_wdata_i
);
  import lfu_pkg::*;

  // Index and rank width; occupancy needs one more value
  localparam int unsigned IB = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned OB = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CW = (OB > CAP_W) ? OB : CAP_W;

  // Search token handed from cell to cell
  typedef struct packed {
    logic                  valid;
    logic                  hit;
    word_t                 hit_val;
    logic [IB-1:0]         hit_rank;
    logic                  have_vic;
    logic [IB-1:0]         vic_idx;
    logic [COUNT_BITS-1:0] vic_cnt;
    logic [IB-1:0]         vic_rank;
    logic                  have_free;
    logic [IB-1:0]         free_idx;
  } tok_t;

  // Update broadcast to all cells on the last sweep cycle
  typedef struct packed {
    op_e           op;
    logic          write_val;
    logic          bump_all;
    logic [IB-1:0] idx;
    logic [IB-1:0] rank;
  } bcast_t;

  state_e             state_d, state_q;
  req_t               req_q;
  logic [CAP_W-1:0]   cap_q;
  logic [OB-1:0]      occ_d, occ_q;
  logic               done_d, done_q;
  rsp_t               rsp_d, rsp_q;
  bcast_t             bcast;
  tok_t               tok_w [MAX_ENTRIES+1];
  tok_t               tail;
  logic [MAX_ENTRIES-1:0] valid_w;
  logic               accept;
  logic               full;

  assign accept = start && !busy;
  assign tail   = tok_w[MAX_ENTRIES];

  // Full when occupancy reaches the capacity, clipped at the store size
  assign full = (CW'(occ_q) >= CW'(cap_q)) || (occ_q == OB'(MAX_ENTRIES));

  // Seed an empty token into the head of the chain
  always_comb begin
    tok_w[0]       = '0;
    tok_w[0].valid = (state_q == S_SEED);
  end

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    lfu_cell #(
      .IDX        (i),
      .IB         (IB),
      .COUNT_BITS (COUNT_BITS),
      .tok_t      (tok_t),
      .bcast_t    (bcast_t)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .req_i   (req_q),
      .bcast_i (bcast),
      .tok_i   (tok_w[i]),
      .tok_o   (tok_w[i+1]),
      .valid_o (valid_w[i])
    );
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_SEED;
        end
      end
      S_SEED: begin
        state_d = S_SWEEP;
      end
      S_SWEEP: begin
        if (tail.valid) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Outputs: decide the update and the response when the token leaves
  always_comb begin
    busy   = (state_q != S_IDLE);
    bcast  = '0;
    bcast.op = OP_NONE;
    occ_d  = occ_q;
    done_d = 1'b0;
    rsp_d  = rsp_q;
    if ((state_q == S_SWEEP) && tail.valid) begin
      done_d      = 1'b1;
      rsp_d.found = tail.hit;
      if (req_q.command == CMD_GET) begin
        rsp_d.read_value = tail.hit ? tail.hit_val : READ_MISS;
        if (tail.hit) begin
          bcast.op   = OP_TOUCH;
          bcast.rank = tail.hit_rank;
        end
      end else begin
        rsp_d.read_value = READ_PUT;
        if (cap_q != '0) begin
          if (tail.hit) begin
            bcast.op        = OP_TOUCH;
            bcast.write_val = 1'b1;
            bcast.rank      = tail.hit_rank;
          end else if (full) begin
            // Evict the victim and reuse its slot
            bcast.op   = OP_FILL;
            bcast.idx  = tail.vic_idx;
            bcast.rank = tail.vic_rank;
          end else begin
            // Take the first free slot; every held entry ages
            bcast.op       = OP_FILL;
            bcast.bump_all = 1'b1;
            bcast.idx      = tail.free_idx;
            occ_d          = occ_q + OB'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cap_q   <= CAP_RESET;
      occ_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      occ_q   <= occ_d;
      done_q  <= done_d;
      if (cfg_we_i) begin
        cap_q <= cfg_wdata_i;
      end
    end
  end

  // Hold the request for the whole sweep; response word needs no reset
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= req_i;
    end
    rsp_q <= rsp_d;
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

  // Token only leaves the chain while a sweep is running
  a_tail_in_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail.valid |-> (state_q == S_SWEEP))
    else $error("search token left the chain outside a sweep");

  // Occupancy counter tracks the cell valid bits
  a_occ_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    OB'($countones(valid_w)) == occ_q)
    else $error("occupancy count differs from valid entries");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OB'(MAX_ENTRIES))
    else $error("occupancy above store size");

  // Every accepted request answers with done_o once its sweep is through
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##(MAX_ENTRIES + 2) done_o)
    else $error("response missing after sweep latency");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (state_q == S_IDLE))
    else $error("response shown while a request is still in flight");

endmodule
